[rtl/rcv_pkg.sv]
// Shared types, constants and lookups for the RIFF container validator.
// Used by rcv_front, rcv_back and riff_container_validator.
package rcv_pkg;

  localparam int QueueDepth = 4;
  localparam int CfgIdxW    = 2;
  localparam int CfgDataW   = 33;
  localparam int OutBits    = 160;

  localparam logic [CfgIdxW-1:0] CFG_AVAIL_LEN  = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_MIN_BODY   = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_MAX_CHUNKS = 2'd2;

  localparam logic [32:0] RstAvailLen  = 33'd0;
  localparam logic [15:0] RstMinBody   = 16'd12;
  localparam logic [15:0] RstMaxChunks = 16'd4096;

  localparam logic [32:0] HdrLen   = 33'd12;
  localparam logic [32:0] ChunkHdr = 33'd8;
  localparam logic [7:0]  AsciiSpace = 8'h20;
  localparam logic [7:0]  AsciiTilde = 8'h7E;

  typedef enum logic [3:0] {
    PH_HEADER = 4'b0001,
    PH_CHUNK  = 4'b0010,
    PH_BODY   = 4'b0100,
    PH_DONE   = 4'b1000
  } phase_t;

  typedef enum logic [3:0] {
    ERR_NONE    = 4'd0,
    ERR_SHORT   = 4'd1,
    ERR_MAGIC   = 4'd2,
    ERR_PASTEND = 4'd3,
    ERR_SMALL   = 4'd4,
    ERR_FORM    = 4'd5,
    ERR_COUNT   = 4'd6,
    ERR_ID      = 4'd7,
    ERR_OVERRUN = 4'd8,
    ERR_TAIL    = 4'd9
  } err_t;

  typedef struct packed {
    logic [7:0] data;
    logic       first;
    logic       printable;
    logic       space;
  } item_t;

  function automatic logic [7:0] magic_byte(input logic [1:0] idx);
    logic [7:0] b;
    case (idx)
      2'd0:    b = 8'h52;
      2'd1:    b = 8'h49;
      default: b = 8'h46;
    endcase
    return b;
  endfunction

  function automatic logic [3:0] form_kind_of(input logic [31:0] form);
    logic [31:0] kinds [8];
    logic [3:0]  kind;
    kinds[0] = {"E", "V", "A", "W"};
    kinds[1] = {" ", "I", "V", "A"};
    kinds[2] = {"P", "B", "E", "W"};
    kinds[3] = {"N", "O", "C", "A"};
    kinds[4] = {"D", "I", "M", "R"};
    kinds[5] = {"k", "b", "f", "s"};
    kinds[6] = {" ", "S", "L", "D"};
    kinds[7] = {" ", "L", "A", "P"};
    kind = 4'd0;
    for (int i = 7; i >= 0; i--) begin
      if (form == kinds[i]) begin
        kind = 4'(i + 1);
      end
    end
    return kind;
  endfunction

endpackage

[rtl/riff_container_validator.sv]
// RIFF container validator, top level: front queue, chunk walker, checks.
// Depends on rcv_pkg, rcv_front and rcv_back.
//
// Usage: stream a candidate file one byte per transfer on s_axis, data in
// tdata, tuser high on byte zero of each file. For each file at most one
// verdict transfer leaves on m_axis, on the byte that decides it; later bytes
// of that file are dropped until tuser marks the next file. The first byte
// after reset counts as byte zero.
// Configuration: write available_length (index 0), min_body_size (index 1)
// and max_chunk_count (index 2) on the cfg channel while no file is in flight;
// cfg_ready is always high.
// Throughput: one byte per clock through the chunk walker while no verdict waits on m_axis_tready.
// With the queue empty, the deciding byte is stored in the queue as it transfers, then judged
// at the queue head; the verdict register it sets drives m_axis_tvalid.
// Reset clears the queue, the walker and the verdict register and loads the
// register defaults 0, 12 and 4096.
// Stall: while a verdict waits on m_axis_tready the walker holds; the queue
// keeps taking up to Depth bytes before s_axis_tready drops.
module riff_container_validator
  import rcv_pkg::*;
#(
  parameter int Depth = QueueDepth
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [7:0]          s_axis_tdata,   // data_byte
  input  logic                s_axis_tuser,   // first_byte
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  // accepted, error_code[4], size_field[32], carve_len[33], form_code[32],
  // first_id[32], chunk_count[16], pad_past_end, form_kind[4], zero fill
  output logic [OutBits-1:0]  m_axis_tdata,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [CfgIdxW-1:0]  cfg_index,
  input  logic [CfgDataW-1:0] cfg_data
);

  item_t head;
  logic  head_valid;
  logic  pop;

  assign cfg_ready = 1'b1;

  rcv_front #(
    .Depth(Depth)
  ) u_front (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .head         (head),
    .head_valid   (head_valid),
    .pop          (pop)
  );

  rcv_back u_back (
    .clk          (clk),
    .rst          (rst),
    .cfg_valid    (cfg_valid && cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .head         (head),
    .head_valid   (head_valid),
    .pop          (pop),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  a_ready_after_reset: assert property (@(posedge clk) rst |=> s_axis_tready)
    else $error("input not ready after reset");

  a_accept_no_error: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tdata[0] |-> m_axis_tdata[4:1] == ERR_NONE)
    else $error("accepted verdict carries an error code");

  a_reject_plain: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tdata[0] |->
      m_axis_tdata[4:1] != ERR_NONE && !m_axis_tdata[150] && m_axis_tdata[154:151] == 4'd0)
    else $error("rejected verdict with pad flag, kind or no code");

  a_accept_has_chunk: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tdata[0] |-> m_axis_tdata[149:134] != 16'd0)
    else $error("accepted verdict without chunks");

endmodule

[rtl/rcv_front.sv]
// Input side: accept bytes, classify them and hold them in a short queue.
// Depends on rcv_pkg.
module rcv_front
  import rcv_pkg::*;
#(
  parameter int Depth = QueueDepth
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,   // data_byte
  input  logic       s_axis_tuser,   // first_byte
  output item_t      head,
  output logic       head_valid,
  input  logic       pop
);

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);

  item_t           mem [Depth];
  logic [PtrW-1:0] wr_ptr;
  logic [PtrW-1:0] rd_ptr;
  logic [CntW-1:0] count;
  logic            push;
  logic            take;
  item_t           in_item;

  assign s_axis_tready = (count != CntW'(Depth));
  assign head_valid    = (count != '0);
  assign push          = s_axis_tvalid && s_axis_tready;
  assign take          = pop && head_valid;
  assign head          = mem[rd_ptr];

  always_comb begin
    in_item.data      = s_axis_tdata;
    in_item.first     = s_axis_tuser;
    in_item.printable = (s_axis_tdata >= AsciiSpace) && (s_axis_tdata <= AsciiTilde);
    in_item.space     = (s_axis_tdata == AsciiSpace);
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= in_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PtrW'(Depth - 1)) ? '0 : wr_ptr + PtrW'(1);
      end
      if (take) begin
        rd_ptr <= (rd_ptr == PtrW'(Depth - 1)) ? '0 : rd_ptr + PtrW'(1);
      end
      if (push && !take) begin
        count <= count + CntW'(1);
      end else if (take && !push) begin
        count <= count - CntW'(1);
      end
    end
  end

endmodule

[rtl/rcv_back.sv]
// Parse side: walk header and chunk list one byte per cycle unless a held verdict stalls, hold verdicts.
// Depends on rcv_pkg; fed by rcv_front.
module rcv_back
  import rcv_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_valid,
  input  logic [CfgIdxW-1:0]  cfg_index,
  input  logic [CfgDataW-1:0] cfg_data,
  input  item_t               head,
  input  logic                head_valid,
  output logic                pop,
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output logic [OutBits-1:0]  m_axis_tdata
);

  logic [32:0] available_length;
  logic [15:0] min_body_size;
  logic [15:0] max_chunk_count;

  phase_t      phase, phase_next;
  logic [3:0]  idx, idx_next;
  logic [31:0] acc, acc_next;
  logic [31:0] body, body_next;
  logic [32:0] left, left_next;
  logic [31:0] riff, riff_next;
  logic [31:0] form, form_next;
  logic [31:0] fid, fid_next;
  logic [15:0] chunks, chunks_next;
  logic        pad, pad_next;

  phase_t      cur_phase;
  logic [3:0]  cur_idx;
  logic [31:0] cur_acc, cur_body, cur_riff, cur_form, cur_fid;
  logic [32:0] cur_left;
  logic [15:0] cur_chunks;
  logic        cur_pad;

  logic        emit, ok, pad_out, do_walk;
  err_t        err;
  logic [32:0] walk_left;
  logic [31:0] b_shift;
  logic [31:0] word;
  logic [32:0] fmt;
  logic [32:0] rem;
  logic [33:0] left1;
  logic        stall;

  logic        o_valid;
  logic        o_ok;
  err_t        o_err;
  logic [31:0] o_riff;
  logic [32:0] o_fmt;
  logic [31:0] o_form;
  logic [31:0] o_fid;
  logic [15:0] o_count;
  logic        o_pad;
  logic [3:0]  o_kind;

  assign stall = o_valid && !m_axis_tready;
  assign pop   = head_valid && !stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      available_length <= RstAvailLen;
      min_body_size    <= RstMinBody;
      max_chunk_count  <= RstMaxChunks;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_AVAIL_LEN:  available_length <= cfg_data;
        CFG_MIN_BODY:   min_body_size    <= cfg_data[15:0];
        CFG_MAX_CHUNKS: max_chunk_count  <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    cur_phase  = head.first ? PH_HEADER : phase;
    cur_idx    = head.first ? 4'd0 : idx;
    cur_acc    = head.first ? 32'd0 : acc;
    cur_body   = head.first ? 32'd0 : body;
    cur_left   = head.first ? 33'd0 : left;
    cur_riff   = head.first ? 32'd0 : riff;
    cur_form   = head.first ? 32'd0 : form;
    cur_fid    = head.first ? 32'd0 : fid;
    cur_chunks = head.first ? 16'd0 : chunks;
    cur_pad    = head.first ? 1'b0 : pad;

    phase_next  = cur_phase;
    idx_next    = cur_idx;
    acc_next    = cur_acc;
    body_next   = cur_body;
    left_next   = cur_left;
    riff_next   = cur_riff;
    form_next   = cur_form;
    fid_next    = cur_fid;
    chunks_next = cur_chunks;
    pad_next    = cur_pad;

    emit      = 1'b0;
    ok        = 1'b0;
    pad_out   = 1'b0;
    err       = ERR_NONE;
    do_walk   = 1'b0;
    walk_left = cur_left;

    b_shift = {24'd0, head.data} << {cur_idx[1:0], 3'b000};
    word    = {head.data, cur_acc[23:0]};
    fmt     = {1'b0, word} + ChunkHdr;
    rem     = cur_left - ChunkHdr;
    left1   = {1'b0, rem} - {2'b00, word};

    case (cur_phase)
      PH_HEADER: begin
        if (cur_idx == 4'd0 && available_length < HdrLen) begin
          emit = 1'b1;
          err  = ERR_SHORT;
        end else if (cur_idx < 4'd4) begin
          if (head.data != magic_byte(cur_idx[1:0])) begin
            emit = 1'b1;
            err  = ERR_MAGIC;
          end else begin
            idx_next = cur_idx + 4'd1;
          end
        end else if (cur_idx < 4'd8) begin
          acc_next = cur_acc | b_shift;
          idx_next = cur_idx + 4'd1;
          if (cur_idx == 4'd7) begin
            riff_next = word;
            acc_next  = 32'd0;
            if (fmt > available_length) begin
              emit = 1'b1;
              err  = ERR_PASTEND;
            end else if (word < {16'd0, min_body_size}) begin
              emit = 1'b1;
              err  = ERR_SMALL;
            end
          end
        end else begin
          if (!head.printable || (cur_idx == 4'd8 && head.space)) begin
            emit = 1'b1;
            err  = ERR_FORM;
          end else begin
            acc_next = cur_acc | b_shift;
            idx_next = cur_idx + 4'd1;
            if (cur_idx >= 4'd11) begin
              form_next = word;
              if (cur_riff < 32'd4) begin
                emit = 1'b1;
                err  = ERR_TAIL;
              end else begin
                left_next = {1'b0, cur_riff} - 33'd4;
                do_walk   = 1'b1;
                walk_left = {1'b0, cur_riff} - 33'd4;
              end
            end
          end
        end
      end
      PH_CHUNK: begin
        if (cur_idx < 4'd4) begin
          if (!head.printable) begin
            emit = 1'b1;
            err  = ERR_ID;
          end else begin
            if (cur_chunks == 16'd0) begin
              fid_next = ((cur_idx == 4'd0) ? 32'd0 : cur_fid) | b_shift;
            end
            idx_next = cur_idx + 4'd1;
          end
        end else begin
          acc_next = cur_acc | b_shift;
          idx_next = cur_idx + 4'd1;
          if (cur_idx >= 4'd7) begin
            if (left1[33]) begin
              emit = 1'b1;
              err  = ERR_OVERRUN;
            end else begin
              chunks_next = cur_chunks + 16'd1;
              left_next   = left1[32:0];
              body_next   = word;
              pad_next    = 1'b0;
              if (word[0]) begin
                if (left1[32:0] == 33'd0) begin
                  emit    = 1'b1;
                  ok      = 1'b1;
                  pad_out = 1'b1;
                end else begin
                  left_next = left1[32:0] - 33'd1;
                  pad_next  = 1'b1;
                end
              end
              if (!emit) begin
                if (word == 32'd0) begin
                  do_walk   = 1'b1;
                  walk_left = left1[32:0];
                end else begin
                  phase_next = PH_BODY;
                end
              end
            end
          end
        end
      end
      PH_BODY: begin
        if (cur_body != 32'd0) begin
          body_next = cur_body - 32'd1;
        end else begin
          pad_next = 1'b0;
        end
        if (body_next == 32'd0 && !pad_next) begin
          do_walk   = 1'b1;
          walk_left = cur_left;
        end
      end
      default: ;
    endcase

    if (do_walk) begin
      if (walk_left >= ChunkHdr) begin
        if (chunks_next >= max_chunk_count) begin
          emit = 1'b1;
          err  = ERR_COUNT;
        end else begin
          phase_next = PH_CHUNK;
          idx_next   = 4'd0;
          acc_next   = 32'd0;
        end
      end else if (walk_left != 33'd0 || chunks_next == 16'd0) begin
        emit = 1'b1;
        err  = ERR_TAIL;
      end else begin
        emit = 1'b1;
        ok   = 1'b1;
      end
    end

    if (emit) begin
      phase_next = PH_DONE;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase  <= PH_HEADER;
      idx    <= 4'd0;
      acc    <= 32'd0;
      body   <= 32'd0;
      left   <= 33'd0;
      riff   <= 32'd0;
      form   <= 32'd0;
      fid    <= 32'd0;
      chunks <= 16'd0;
      pad    <= 1'b0;
    end else if (pop) begin
      phase  <= phase_next;
      idx    <= idx_next;
      acc    <= acc_next;
      body   <= body_next;
      left   <= left_next;
      riff   <= riff_next;
      form   <= form_next;
      fid    <= fid_next;
      chunks <= chunks_next;
      pad    <= pad_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      o_valid <= 1'b0;
    end else begin
      o_valid <= (pop && emit) || stall;
    end
  end

  always_ff @(posedge clk) begin
    if (pop && emit) begin
      o_ok    <= ok;
      o_err   <= err;
      o_riff  <= riff_next;
      o_fmt   <= (cur_phase != PH_HEADER || cur_idx >= 4'd7)
                 ? ({1'b0, riff_next} + ChunkHdr) : 33'd0;
      o_form  <= form_next;
      o_fid   <= (chunks_next != 16'd0) ? fid_next : 32'd0;
      o_count <= chunks_next;
      o_pad   <= ok && pad_out;
      o_kind  <= ok ? form_kind_of(form_next) : 4'd0;
    end
  end

  assign m_axis_tvalid = o_valid;
  assign m_axis_tdata  = {5'd0, o_kind, o_pad, o_count, o_fid, o_form, o_fmt, o_riff,
                          o_err, o_ok};

endmodule

[tb/riff_validator_checker.sv]
// Scoreboard for the RIFF container validator: tracks config writes and
// byte transfers, predicts each verdict and compares it with m_axis output.
// Depends on rcv_pkg.
`timescale 1ns / 100ps

module riff_validator_checker
  import rcv_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                s_axis_tvalid,
  input  logic                s_axis_tready,
  input  logic [7:0]          s_axis_tdata,
  input  logic                s_axis_tuser,
  input  logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  input  logic [OutBits-1:0]  m_axis_tdata,
  input  logic                cfg_valid,
  input  logic                cfg_ready,
  input  logic [CfgIdxW-1:0]  cfg_index,
  input  logic [CfgDataW-1:0] cfg_data,
  output int                  mismatch_count,
  output int                  pending
);

  typedef struct packed {
    logic [4:0]  fill;
    logic [3:0]  kind;
    logic        pad;
    logic [15:0] count;
    logic [31:0] first_id;
    logic [31:0] form;
    logic [32:0] fmt_size;
    logic [31:0] riff;
    err_t        err;
    logic        ok;
  } verdict_t;

  verdict_t    verdict_q[$];
  verdict_t    got;
  verdict_t    want;

  logic [32:0] avail_len;
  logic [15:0] min_body;
  logic [15:0] chunk_cap;

  phase_t      phase;
  logic [3:0]  fidx;
  logic [31:0] acc;
  logic [32:0] body_left;
  logic [32:0] end_left;
  logic [31:0] riff_sz;
  logic [31:0] form;
  logic [31:0] first_id;
  logic [15:0] nchunks;
  logic        pad_pend;
  logic        decided;

  task clear_parse();
    phase     = PH_HEADER;
    fidx      = '0;
    acc       = '0;
    body_left = '0;
    end_left  = '0;
    riff_sz   = '0;
    form      = '0;
    first_id  = '0;
    nchunks   = '0;
    pad_pend  = 1'b0;
    decided   = 1'b0;
  endtask

  function automatic logic [3:0] kind_of(input logic [31:0] f);
    logic [3:0] k;
    case (f)
      "EVAW":  k = 4'd1;
      " IVA":  k = 4'd2;
      "PBEW":  k = 4'd3;
      "NOCA":  k = 4'd4;
      "DIMR":  k = 4'd5;
      "kbfs":  k = 4'd6;
      " SLD":  k = 4'd7;
      " LAP":  k = 4'd8;
      default: k = 4'd0;
    endcase
    return k;
  endfunction

  function automatic string show(input verdict_t v);
    return $sformatf("ok=%0d err=%0d riff=%h fmt=%h form=%h id=%h cnt=%0d pad=%0d kind=%0d fill=%h",
                     v.ok, v.err, v.riff, v.fmt_size, v.form, v.first_id, v.count, v.pad,
                     v.kind, v.fill);
  endfunction

  task post_verdict(input logic ok, input err_t code, input logic pad);
    verdict_t v;
    logic     size_known;
    size_known = (phase != PH_HEADER) || (fidx >= 4'd7);
    v.fill     = '0;
    v.ok       = ok;
    v.err      = code;
    v.riff     = size_known ? riff_sz : 32'd0;
    v.fmt_size = size_known ? ({1'b0, riff_sz} + 33'd8) : 33'd0;
    v.form     = form;
    v.first_id = (nchunks != 16'd0) ? first_id : 32'd0;
    v.count    = nchunks;
    v.pad      = ok & pad;
    v.kind     = ok ? kind_of(form) : 4'd0;
    verdict_q.push_back(v);
    decided = 1'b1;
    phase   = PH_DONE;
  endtask

  task next_chunk_or_close();
    if (end_left >= ChunkHdr) begin
      if (nchunks >= chunk_cap) begin
        post_verdict(1'b0, ERR_COUNT, 1'b0);
      end else begin
        phase = PH_CHUNK;
        fidx  = '0;
        acc   = '0;
      end
    end else if (end_left != 33'd0 || nchunks == 16'd0) begin
      post_verdict(1'b0, ERR_TAIL, 1'b0);
    end else begin
      post_verdict(1'b1, ERR_NONE, 1'b0);
    end
  endtask

  task advance_parse(input logic [7:0] b, input logic first);
    logic [3:0]  idx;
    logic [4:0]  sh;
    logic [31:0] csize;
    logic [32:0] fmt;
    logic [7:0]  magic;
    logic        printable;
    if (first) clear_parse();
    if (decided || phase == PH_DONE) return;
    idx       = fidx;
    sh        = {idx[1:0], 3'b000};
    printable = (b >= AsciiSpace) && (b <= AsciiTilde);
    case (phase)
      PH_HEADER: begin
        if (idx == 4'd0 && avail_len < HdrLen) begin
          post_verdict(1'b0, ERR_SHORT, 1'b0);
          return;
        end
        if (idx < 4'd4) begin
          magic = (idx == 4'd0) ? 8'h52 : (idx == 4'd1) ? 8'h49 : 8'h46;
          if (b != magic) begin
            post_verdict(1'b0, ERR_MAGIC, 1'b0);
            return;
          end
        end else if (idx < 4'd8) begin
          acc |= {24'd0, b} << sh;
          if (idx == 4'd7) begin
            riff_sz = acc;
            acc     = '0;
            if ({1'b0, riff_sz} + 33'd8 > avail_len) begin
              post_verdict(1'b0, ERR_PASTEND, 1'b0);
              return;
            end
            if (riff_sz < {16'd0, min_body}) begin
              post_verdict(1'b0, ERR_SMALL, 1'b0);
              return;
            end
          end
        end else begin
          if (!printable || (idx == 4'd8 && b == AsciiSpace)) begin
            post_verdict(1'b0, ERR_FORM, 1'b0);
            return;
          end
          acc |= {24'd0, b} << sh;
          if (idx >= 4'd11) begin
            form = acc;
            fmt  = {1'b0, riff_sz} + 33'd8;
            if (fmt < HdrLen) begin
              post_verdict(1'b0, ERR_TAIL, 1'b0);
              return;
            end
            end_left = fmt - HdrLen;
            next_chunk_or_close();
            return;
          end
        end
        fidx = idx + 4'd1;
      end
      PH_CHUNK: begin
        if (idx < 4'd4) begin
          if (!printable) begin
            post_verdict(1'b0, ERR_ID, 1'b0);
            return;
          end
          if (nchunks == 16'd0) begin
            if (idx == 4'd0) first_id = '0;
            first_id |= {24'd0, b} << sh;
          end
        end else begin
          acc |= {24'd0, b} << sh;
          if (idx >= 4'd7) begin
            csize = acc;
            if ({1'b0, csize} > end_left - ChunkHdr) begin
              post_verdict(1'b0, ERR_OVERRUN, 1'b0);
              return;
            end
            nchunks   = nchunks + 16'd1;
            end_left  = end_left - ChunkHdr - {1'b0, csize};
            body_left = {1'b0, csize};
            pad_pend  = 1'b0;
            if (csize[0]) begin
              if (end_left == 33'd0) begin
                post_verdict(1'b1, ERR_NONE, 1'b1);
                return;
              end
              end_left = end_left - 33'd1;
              pad_pend = 1'b1;
            end
            if (body_left == 33'd0 && !pad_pend) next_chunk_or_close();
            else phase = PH_BODY;
            return;
          end
        end
        fidx = idx + 4'd1;
      end
      PH_BODY: begin
        if (body_left != 33'd0) body_left = body_left - 33'd1;
        else pad_pend = 1'b0;
        if (body_left == 33'd0 && !pad_pend) next_chunk_or_close();
      end
      default: begin
      end
    endcase
  endtask

  always @(posedge clk) begin
    if (rst) begin
      avail_len = RstAvailLen;
      min_body  = RstMinBody;
      chunk_cap = RstMaxChunks;
      clear_parse();
      verdict_q.delete();
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        got = verdict_t'(m_axis_tdata);
        if (verdict_q.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 10) $display("%0t: verdict with none expected: %s", $time,
                                             show(got));
        end else begin
          want = verdict_q.pop_front();
          if (got !== want) begin
            mismatch_count++;
            if (mismatch_count <= 10) begin
              $display("%0t: verdict mismatch", $time);
              $display("  expected %s", show(want));
              $display("  actual   %s", show(got));
            end
          end
        end
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_AVAIL_LEN:  avail_len = cfg_data;
          CFG_MIN_BODY:   min_body  = cfg_data[15:0];
          CFG_MAX_CHUNKS: chunk_cap = cfg_data[15:0];
          default: begin
          end
        endcase
      end
      if (s_axis_tvalid && s_axis_tready) advance_parse(s_axis_tdata, s_axis_tuser);
    end
    pending = verdict_q.size();
  end

endmodule

[tb/tb_riff_container_validator.sv]
// Top-level bench for riff_container_validator: directed and random RIFF
// byte streams over several register settings, with random stalls on both sides.
// Depends on rcv_pkg, the validator RTL and riff_validator_checker.
`timescale 1ns / 100ps

module tb_riff_container_validator;
  import rcv_pkg::*;

  localparam logic [32:0]        AvailMax     = 33'h1_0000_0007;
  localparam logic [CfgIdxW-1:0] CfgSpare     = 2'd3;
  localparam int                 CycleLimit   = 200000;
  localparam int                 HoldCycles   = 400;
  localparam int                 SettleCycles = 16;

  logic                clk;
  logic                rst           = 1'b1;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [7:0]          s_axis_tdata  = 8'd0;
  logic                s_axis_tuser  = 1'b0;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [OutBits-1:0]  m_axis_tdata;
  logic                cfg_valid     = 1'b0;
  logic                cfg_ready;
  logic [CfgIdxW-1:0]  cfg_index     = '0;
  logic [CfgDataW-1:0] cfg_data      = '0;

  int mismatch_count;
  int pending;
  int cycle_count   = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int hold_requests = 0;
  int holds_served  = 0;
  int hold_left     = 0;

  logic [8:0] file_bytes[$];

  riff_container_validator dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  riff_validator_checker u_check (
    .clk            (clk),
    .rst            (rst),
    .s_axis_tvalid  (s_axis_tvalid),
    .s_axis_tready  (s_axis_tready),
    .s_axis_tdata   (s_axis_tdata),
    .s_axis_tuser   (s_axis_tuser),
    .m_axis_tvalid  (m_axis_tvalid),
    .m_axis_tready  (m_axis_tready),
    .m_axis_tdata   (m_axis_tdata),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .mismatch_count (mismatch_count),
    .pending        (pending)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    while (cycle_count < CycleLimit) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("tb_riff_container_validator: FAIL");
    $finish;
  end

  // hold off for a long stretch on request, else stall at random
  initial begin
    forever begin
      @(negedge clk);
      if (hold_left != 0) begin
        m_axis_tready <= 1'b0;
        hold_left--;
      end else if (hold_requests != holds_served) begin
        hold_left = HoldCycles;
        holds_served++;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  task automatic send_byte(input logic [7:0] b, input logic first);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    s_axis_tuser  <= first;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic send_file(inout int sent);
    foreach (file_bytes[i]) send_byte(file_bytes[i][7:0], file_bytes[i][8]);
    sent += file_bytes.size();
  endtask

  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (SettleCycles) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic configure(input logic [32:0] avail, input logic [15:0] min_sz,
                           input logic [15:0] cap);
    wait_idle();
    write_reg(CFG_AVAIL_LEN, avail);
    write_reg(CFG_MIN_BODY, {17'd0, min_sz});
    write_reg(CFG_MAX_CHUNKS, {17'd0, cap});
    cfg_valid <= 1'b0;
  endtask

  task automatic put_byte(input logic [7:0] b);
    file_bytes.push_back({1'b0, b});
  endtask

  function automatic logic [7:0] rand_printable();
    return 8'($urandom_range(8'h7E, 8'h20));
  endfunction

  task automatic build_file();
    logic [7:0]  body[$];
    logic [31:0] riff;
    logic [31:0] riff_alt;
    logic [31:0] fourcc;
    logic        pad_out;
    int          nchunks;
    int          csize;
    int          pick;
    int          cut;
    int          pos;
    file_bytes.delete();
    pick = $urandom_range(99);
    if (pick < 12) begin
      repeat ($urandom_range(16, 1)) file_bytes.push_back({$urandom_range(7) == 0, 8'($urandom)});
      file_bytes[0][8] = 1'b1;
      return;
    end
    if ($urandom_range(1) == 1) begin
      case ($urandom_range(7))
        0: fourcc = "EVAW";
        1: fourcc = " IVA";
        2: fourcc = "PBEW";
        3: fourcc = "NOCA";
        4: fourcc = "DIMR";
        5: fourcc = "kbfs";
        6: fourcc = " SLD";
        default: fourcc = " LAP";
      endcase
    end else begin
      fourcc = {rand_printable(), rand_printable(), rand_printable(),
                8'($urandom_range(8'h7E, 8'h21))};
    end
    for (int k = 0; k < 4; k++) body.push_back(fourcc[8*k +: 8]);
    nchunks = $urandom_range(4);
    pad_out = 1'b0;
    for (int c = 0; c < nchunks; c++) begin
      csize = ($urandom_range(9) == 0) ? $urandom_range(40) : $urandom_range(9);
      repeat (4) body.push_back(rand_printable());
      for (int k = 0; k < 4; k++) body.push_back(8'(csize >> (8 * k)));
      repeat (csize) body.push_back(8'($urandom));
      if (csize % 2 == 1) begin
        if (c == nchunks - 1 && $urandom_range(1) == 1) pad_out = 1'b1;
        else body.push_back(8'($urandom));
      end
    end
    riff = body.size();
    if ($urandom_range(19) == 0) riff = $urandom_range(3);
    put_byte(8'h52);
    put_byte(8'h49);
    put_byte(8'h46);
    put_byte(8'h46);
    for (int k = 0; k < 4; k++) put_byte(riff[8*k +: 8]);
    foreach (body[i]) put_byte(body[i]);
    pick = $urandom_range(99);
    if (pick < 10) begin
      pos = $urandom_range(file_bytes.size() - 1);
      file_bytes[pos] = {1'b0, 8'($urandom)};
    end else if (pick < 15) begin
      riff_alt = riff + 32'($urandom_range(6)) - 32'd3;
      for (int k = 0; k < 4; k++) file_bytes[4 + k] = {1'b0, riff_alt[8*k +: 8]};
    end else if (pick < 20) begin
      cut = $urandom_range(file_bytes.size() - 1, 1);
      while (file_bytes.size() > cut) void'(file_bytes.pop_back());
    end else if (pick < 25) begin
      repeat ($urandom_range(6, 1)) put_byte(8'($urandom));
    end
    file_bytes[0][8] = 1'b1;
  endtask

  task automatic run_random(input int budget);
    int sent;
    sent = 0;
    while (sent < budget) begin
      build_file();
      send_file(sent);
    end
  endtask

  initial begin
    int sent;
    sent = 0;
    repeat (11) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // defaults: nothing available, first byte after reset needs no tuser
    file_bytes = '{9'h052, 9'h000, 9'h1FF};
    send_file(sent);
    configure(33'd11, RstMinBody, RstMaxChunks);
    file_bytes = '{9'h152};
    send_file(sent);
    configure(AvailMax, RstMinBody, RstMaxChunks);
    write_reg(CfgSpare, 33'h1_5555_5555);
    cfg_valid <= 1'b0;
    file_bytes = '{9'h152, 9'h058};
    send_file(sent);
    file_bytes = '{9'h152, 9'h049, 9'h046, 9'h046, 9'h0FF, 9'h0FF, 9'h0FF, 9'h0FF, 9'h020};
    send_file(sent);
    file_bytes = '{9'h152, 9'h049, 9'h046, 9'h046, 9'h000, 9'h000, 9'h000, 9'h000};
    send_file(sent);

    send_idle_pct = 10;
    recv_idle_pct = 52;
    run_random(350);
    configure(33'($urandom_range(120, 12)), 16'd4, 16'd3);
    run_random(350);

    send_idle_pct = 52;
    recv_idle_pct = 10;
    configure(HdrLen, 16'd65535, RstMaxChunks);
    run_random(200);
    configure(AvailMax, 16'd2, 16'd1);
    run_random(300);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    configure(33'd60, 16'd4, 16'd0);
    run_random(200);
    configure(AvailMax, RstMinBody, 16'd65535);
    hold_requests++;
    run_random(350);

    wait_idle();
    if (mismatch_count == 0 && pending == 0) begin
      $display("tb_riff_container_validator: PASS");
    end else begin
      $display("tb_riff_container_validator: FAIL");
    end
    $finish;
  end

endmodule

[sim.f]
rtl/rcv_pkg.sv
rtl/rcv_front.sv
rtl/rcv_back.sv
rtl/riff_container_validator.sv
tb/riff_validator_checker.sv
tb/tb_riff_container_validator.sv
